>>> hw/rtl/ring_queue_with_skip_marks_top_assert.svh
// Assertion macros shared by the ring queue with skip marks.
`ifndef RING_QUEUE_WITH_SKIP_MARKS_TOP_ASSERT_SVH
`define RING_QUEUE_WITH_SKIP_MARKS_TOP_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RQSM_CHECK_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RQSM_CHECK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/rqsm_pkg.sv
// Types and constants shared by the ring queue with skip marks.
`timescale 1ns / 1ps
package rqsm_pkg;

  localparam int DEPTH  = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ITEM_W = 32;
  localparam int CNT_W  = ADDR_W + 1;
  localparam int LIVE_W = 5;
  localparam int OP_W   = 2;
  localparam int ERR_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_MARK  = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POPRD,
    S_SCAN,
    S_READ,
    S_LOAD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [ITEM_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic [ITEM_W-1:0] item;
    logic              empty;
    logic              full;
    logic [LIVE_W-1:0] live;
    logic              marked;
    logic [ADDR_W-1:0] head;
    logic [ADDR_W-1:0] tail;
    err_t              err;
  } res_t;

endpackage

>>> hw/rtl/rqsm_mem.sv
// Payload memory: one write port and one registered read port.
`timescale 1ns / 1ps
module rqsm_mem (
  input  logic                      clk,
  input  rqsm_pkg::mem_wr_t         wr,
  input  logic [rqsm_pkg::ADDR_W-1:0] raddr,
  output logic [rqsm_pkg::ITEM_W-1:0] rdata
);
  import rqsm_pkg::*;

  logic [ITEM_W-1:0] mem [DEPTH];
  logic [ITEM_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/rqsm_ctrl.sv
// Sequencer, pointers and skip marks; the skip scan steps one slot a cycle.
`timescale 1ns / 1ps
module rqsm_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [rqsm_pkg::OP_W-1:0]   in_op,
  input  logic [rqsm_pkg::ITEM_W-1:0] in_data,
  input  logic [rqsm_pkg::ADDR_W-1:0] in_index,
  output logic                        in_ready,
  output logic                        res_valid,
  input  logic                        res_take,
  output rqsm_pkg::res_t              res,
  output rqsm_pkg::mem_wr_t           mem_wr,
  output logic [rqsm_pkg::ADDR_W-1:0] mem_raddr,
  input  logic [rqsm_pkg::ITEM_W-1:0] mem_rdata
);
  import rqsm_pkg::*;

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [ITEM_W-1:0] data_r, data_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [ADDR_W-1:0] tail_r, tail_nxt;
  logic [DEPTH-1:0]  marks_r, marks_nxt;
  logic [CNT_W-1:0]  mcnt_r, mcnt_nxt;
  logic [ITEM_W-1:0] item_r, item_nxt;
  err_t              err_r, err_nxt;

  logic [ADDR_W-1:0] occ;
  logic [ADDR_W-1:0] head_inc;
  logic [CNT_W-1:0]  occ_ext;
  logic              is_empty;

  // Pointer arithmetic wraps naturally since the depth is a power of two.
  assign occ      = tail_r - head_r;
  assign head_inc = head_r + ADDR_W'(1);
  assign occ_ext  = {1'b0, occ};
  assign is_empty = (head_r == tail_r);

  assign mem_raddr = head_r;
  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_OUT);

  always_comb begin
    res.item   = item_r;
    res.empty  = is_empty;
    res.full   = (occ == ADDR_W'(DEPTH - 1));
    res.live   = (occ_ext > mcnt_r) ? LIVE_W'(occ_ext - mcnt_r) : '0;
    res.marked = marks_r[idx_r];
    res.head   = head_r;
    res.tail   = tail_r;
    res.err    = err_r;
  end

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    data_nxt    = data_r;
    idx_nxt     = idx_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    marks_nxt   = marks_r;
    mcnt_nxt    = mcnt_r;
    item_nxt    = item_r;
    err_nxt     = err_r;
    mem_wr.we   = 1'b0;
    mem_wr.addr = tail_r;
    mem_wr.data = data_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = op_t'(in_op);
          data_nxt  = in_data;
          idx_nxt   = in_index;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        err_nxt   = ERR_NONE;
        state_nxt = S_READ;
        case (op_r)
          OP_PUSH: begin
            if (occ == ADDR_W'(DEPTH - 1)) begin
              err_nxt = ERR_FULL;
            end else begin
              mem_wr.we = 1'b1;
              tail_nxt  = tail_r + ADDR_W'(1);
            end
          end
          OP_POP: begin
            if (is_empty) begin
              err_nxt = ERR_EMPTY;
            end else begin
              // The read of the old head lands in the next cycle.
              head_nxt  = head_inc;
              state_nxt = S_POPRD;
            end
          end
          OP_MARK: begin
            if (!marks_r[idx_r]) begin
              marks_nxt[idx_r] = 1'b1;
              mcnt_nxt         = mcnt_r + CNT_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
      S_POPRD: begin
        item_nxt  = mem_rdata;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        // Walk past marked slots one per cycle, never beyond the tail.
        if (is_empty || !marks_r[head_r]) begin
          state_nxt = S_OUT;
        end else begin
          marks_nxt[head_r] = 1'b0;
          mcnt_nxt          = mcnt_r - CNT_W'(1);
          head_nxt          = head_inc;
        end
      end
      S_READ: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        item_nxt  = is_empty ? '0 : mem_rdata;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      marks_r <= '0;
      mcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      marks_r <= marks_nxt;
      mcnt_r  <= mcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    data_r <= data_nxt;
    idx_r  <= idx_nxt;
    item_r <= item_nxt;
    err_r  <= err_nxt;
  end

endmodule

>>> hw/rtl/ring_queue_with_skip_marks_top.sv
// Top level of the ring queue with skip marks: sequencer, payload memory, result register.
`timescale 1ns / 1ps
`include "ring_queue_with_skip_marks_top_assert.svh"
// A 32-slot circular queue of 32-bit words with one skip mark per slot. Each
// item (push, pop, mark or status query) yields one result describing the
// queue afterwards. A push, mark or query passes through the execute, read
// and load states; a pop goes from execute through the pop read and then
// skips the consecutive marked slots after the popped one, since the head
// pointer walks one slot per cycle through the shared increment and compare.
// The payload memory has a single registered read port on the head pointer,
// which sets the read latency. One item is processed at a time; the result
// register lets the next item be accepted while a result still waits to be taken.
module ring_queue_with_skip_marks_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rqsm_pkg::OP_W-1:0]   in_op,
  input  logic [rqsm_pkg::ITEM_W-1:0] in_data,
  input  logic [rqsm_pkg::ADDR_W-1:0] in_index,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rqsm_pkg::ITEM_W-1:0] out_item,
  output logic                        out_empty_res,
  output logic                        out_full_res,
  output logic [rqsm_pkg::LIVE_W-1:0] out_live_count,
  output logic                        out_index_is_marked,
  output logic [rqsm_pkg::ADDR_W-1:0] out_head_index,
  output logic [rqsm_pkg::ADDR_W-1:0] out_tail_index,
  output logic [rqsm_pkg::ERR_W-1:0]  out_error
);
  import rqsm_pkg::*;

  logic              in_ready;
  logic              res_valid;
  logic              res_take;
  res_t              res;
  mem_wr_t           mem_wr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [ITEM_W-1:0] mem_rdata;

  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  rqsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_data   (in_data),
    .in_index  (in_index),
    .in_ready  (in_ready),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .mem_wr    (mem_wr),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  rqsm_mem u_mem (
    .clk   (clk),
    .wr    (mem_wr),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_stall = !in_ready;

  // A new result loads once the held one is taken or the register is empty.
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_item            = out_res_r.item;
  assign out_empty_res       = out_res_r.empty;
  assign out_full_res        = out_res_r.full;
  assign out_live_count      = out_res_r.live;
  assign out_index_is_marked = out_res_r.marked;
  assign out_head_index      = out_res_r.head;
  assign out_tail_index      = out_res_r.tail;
  assign out_error           = out_res_r.err;

  `RQSM_CHECK_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted item did not stall input")
  `RQSM_CHECK_NOW(a_full_err, out_valid && (out_error == ERR_FULL), out_full_res, "push rejected while not full")
  `RQSM_CHECK_NOW(a_empty_err, out_valid && (out_error == ERR_EMPTY), out_empty_res && (out_item == '0), "pop rejected with bad result")
  `RQSM_CHECK_NOW(a_empty_live, out_valid && out_empty_res, (out_live_count == '0) && (out_head_index == out_tail_index), "empty queue reports live items")

endmodule
